/* sv/mie_pkg.sv */
// ----------------------------------------------------------------------------
// mie_pkg: shared types and codes of the MIPS32 integer execute block.
// Opcode and function codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;

  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;
  localparam logic [4:0] RT_BLTZAL  = 5'd16;
  localparam logic [4:0] RT_BGEZAL  = 5'd17;

  localparam logic [4:0] LINK_REG   = 5'd31;
  localparam int         DIV_STEPS  = 32;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item and decode it
    logic mul_lo;    // first multiply pass: low partial products
    logic mul_hi;    // second multiply pass
    logic div_step;  // one restoring divide step
    logic div_fix;   // sign correction and HI/LO update
    logic out_load;  // present the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } sts_t;

endpackage

/* sv/mie_ctrl.sv */
// ----------------------------------------------------------------------------
// mie_ctrl: controller of the MIPS32 integer execute block.
// Sequences input capture, multiply passes, divide steps and output.
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  mie_pkg::sts_t sts,
  output mie_pkg::cmd_t cmd
);
  import mie_pkg::*;

  state_t state_r, state_nxt;
  logic   mul_pass_r, mul_pass_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin;

  // An item finishes in the cycle its last step runs.
  assign fin = (state_r == ST_IDLE && in_tvalid && !sts.is_mul && !sts.is_div)
             || (state_r == ST_MUL && mul_pass_r) || (state_r == ST_FIX);

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    mul_pass_nxt = mul_pass_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tready && in_tvalid) begin
          if (sts.is_mul) begin
            state_nxt    = ST_MUL;
            mul_pass_nxt = 1'b0;
          end else if (sts.is_div) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_MUL: begin
        mul_pass_nxt = 1'b1;
        if (mul_pass_r) state_nxt = ST_IDLE;
      end
      ST_DIV: if (sts.div_last) state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and the result valid flag.
  always_comb begin
    cmd           = '0;
    in_tready     = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
    cmd.load      = in_tready && in_tvalid;
    cmd.mul_lo    = (state_r == ST_MUL) && !mul_pass_r;
    cmd.mul_hi    = (state_r == ST_MUL) && mul_pass_r;
    cmd.div_step  = (state_r == ST_DIV);
    cmd.div_fix   = (state_r == ST_FIX);
    cmd.out_load  = cmd.load;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (fin && (state_r != ST_IDLE || cmd.load)) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_pass_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_pass_r  <= mul_pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // No item is taken while a multiply or divide is in flight.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input taken while busy");
  // A pending result is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped");
  // The fix step always follows the last divide step.
  a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> (state_r == ST_FIX))
    else $error("divide fix skipped");
`endif

endmodule

/* sv/mie_dp.sv */
// ----------------------------------------------------------------------------
// mie_dp: datapath of the MIPS32 integer execute block.
// Decode, ALU, branch unit, HI/LO, a two-pass multiplier and a divider.
// ----------------------------------------------------------------------------
module mie_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   instruction,
  input  logic [31:0]   rs_value,
  input  logic [31:0]   rt_value,
  input  logic [31:0]   pc,
  input  mie_pkg::cmd_t cmd,
  output mie_pkg::sts_t sts,
  output logic [79:0]   result
);
  import mie_pkg::*;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sa, shamt;
  logic [15:0] imm;
  logic [31:0] simm, pc4, btgt, link, jtgt, val, tgt;
  logic [4:0]  dst;
  logic        wr, br, sys, unk, neg;
  logic        is_mul, is_div, div_last;
  logic        hi_we, lo_we;
  logic [31:0] hi_new, lo_new, shl, shr, sar;

  logic [31:0] hi_r, lo_r;
  logic [31:0] ma_r, mb_r;
  logic        msign_r, qneg_r, rneg_r, divz_r;
  logic [31:0] dvd_r, dvsr_r, a_r, rem_r, quo_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [31:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0] prod;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [79:0] res_r;

  assign op    = instruction[31:26];
  assign rt    = instruction[20:16];
  assign rd    = instruction[15:11];
  assign sa    = instruction[10:6];
  assign fn    = instruction[5:0];
  assign imm   = instruction[15:0];
  assign simm  = {{16{imm[15]}}, imm};
  assign pc4   = pc + 32'd4;
  assign btgt  = pc4 + {simm[29:0], 2'b00};
  assign link  = pc + 32'd8;
  assign jtgt  = {btgt[31:28] & 4'h0 | (pc[31:28] + {3'b000, &pc[27:2]}),
                  instruction[25:0], 2'b00};
  assign neg   = rs_value[31];
  assign shamt = (fn == FN_SLLV || fn == FN_SRLV || fn == FN_SRAV) ? rs_value[4:0] : sa;
  assign shl   = rt_value << shamt;
  assign shr   = rt_value >> shamt;
  assign sar   = $unsigned($signed(rt_value) >>> shamt);

  // Decode and combinational execution.
  always_comb begin
    wr = 1'b0; br = 1'b0; sys = 1'b0; unk = 1'b0;
    dst = '0; val = '0; tgt = '0;
    hi_we = 1'b0; lo_we = 1'b0; hi_new = rs_value; lo_new = rs_value;
    is_mul = 1'b0; is_div = 1'b0;
    case (op)
      OP_SPECIAL: begin
        dst = rd; wr = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: val = rs_value + rt_value;
          FN_SUB, FN_SUBU: val = rs_value - rt_value;
          FN_AND:  val = rs_value & rt_value;
          FN_OR:   val = rs_value | rt_value;
          FN_XOR:  val = rs_value ^ rt_value;
          FN_NOR:  val = ~(rs_value | rt_value);
          FN_SLT:  val = {31'd0, $signed(rs_value) < $signed(rt_value)};
          FN_SLTU: val = {31'd0, rs_value < rt_value};
          FN_SLL, FN_SLLV: val = shl;
          FN_SRL, FN_SRLV: val = shr;
          FN_SRA, FN_SRAV: val = sar;
          FN_MFHI: val = hi_r;
          FN_MFLO: val = lo_r;
          FN_JALR: begin val = link; br = 1'b1; tgt = rs_value; end
          FN_JR:   begin wr = 1'b0; br = 1'b1; tgt = rs_value; end
          FN_SYSCALL: begin wr = 1'b0; sys = 1'b1; end
          FN_MTHI: begin wr = 1'b0; hi_we = 1'b1; end
          FN_MTLO: begin wr = 1'b0; lo_we = 1'b1; end
          FN_MULT, FN_MULTU: begin wr = 1'b0; is_mul = 1'b1; end
          FN_DIV, FN_DIVU:   begin wr = 1'b0; is_div = 1'b1; end
          default: begin wr = 1'b0; unk = 1'b1; end
        endcase
      end
      OP_ADDI, OP_ADDIU: begin dst = rt; wr = 1'b1; val = rs_value + simm; end
      OP_SLTI:  begin dst = rt; wr = 1'b1;
                  val = {31'd0, $signed(rs_value) < $signed(simm)}; end
      OP_SLTIU: begin dst = rt; wr = 1'b1; val = {31'd0, rs_value < simm}; end
      OP_ANDI:  begin dst = rt; wr = 1'b1; val = rs_value & {16'd0, imm}; end
      OP_ORI:   begin dst = rt; wr = 1'b1; val = rs_value | {16'd0, imm}; end
      OP_XORI:  begin dst = rt; wr = 1'b1; val = rs_value ^ {16'd0, imm}; end
      OP_LUI:   begin dst = rt; wr = 1'b1; val = {imm, 16'd0}; end
      OP_REGIMM: begin
        case (rt)
          RT_BLTZ:   br = neg;
          RT_BGEZ:   br = !neg;
          RT_BLTZAL: begin br = neg;  wr = 1'b1; dst = LINK_REG; val = link; end
          RT_BGEZAL: begin br = !neg; wr = 1'b1; dst = LINK_REG; val = link; end
          default:   unk = 1'b1;
        endcase
        if (br) tgt = btgt;
      end
      OP_BEQ:  begin br = (rs_value == rt_value); if (br) tgt = btgt; end
      OP_BNE:  begin br = (rs_value != rt_value); if (br) tgt = btgt; end
      OP_BLEZ: begin br = (rs_value == 32'd0) || neg; if (br) tgt = btgt; end
      OP_BGTZ: begin br = (rs_value != 32'd0) && !neg; if (br) tgt = btgt; end
      OP_J:    begin br = 1'b1; tgt = {pc4[31:28], instruction[25:0], 2'b00}; end
      OP_JAL:  begin br = 1'b1; tgt = {pc4[31:28], instruction[25:0], 2'b00};
                 wr = 1'b1; dst = LINK_REG; val = link; end
      default: unk = 1'b1;
    endcase
    if (!wr || dst == 5'd0) begin wr = 1'b0; dst = '0; val = '0; end
  end

  // Multiplier: 16x16 partial products over two passes on magnitudes.
  assign pp_ll = ma_r[15:0]  * mb_r[15:0];
  assign pp_lh = ma_r[15:0]  * mb_r[31:16];
  assign pp_hl = ma_r[31:16] * mb_r[15:0];
  assign pp_hh = ma_r[31:16] * mb_r[31:16];
  assign prod  = acc_r + {pp_hh, 32'd0};

  // Restoring divider step on magnitudes.
  assign rem_sh   = {rem_r[30:0], dvd_r[31]};
  assign trial    = {rem_r, dvd_r[31]} - {1'b0, dvsr_r};
  assign div_last = (cnt_r == 6'(DIV_STEPS - 1));

  // Status toward the controller.
  assign sts = {is_mul, is_div, div_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      if (cmd.load && hi_we) hi_r <= hi_new;
      if (cmd.load && lo_we) lo_r <= lo_new;
      if (cmd.mul_hi) begin
        hi_r <= msign_r ? ~prod[63:32] + {31'd0, prod[31:0] == 32'd0} : prod[63:32];
        lo_r <= msign_r ? ~prod[31:0] + 32'd1 : prod[31:0];
      end
      if (cmd.div_fix) begin
        if (divz_r) begin
          lo_r <= '1;
          hi_r <= a_r;
        end else begin
          lo_r <= qneg_r ? 32'd0 - quo_r : quo_r;
          hi_r <= rneg_r ? 32'd0 - rem_r : rem_r;
        end
      end
    end
  end

  // Operand capture and iteration registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msign_r <= (fn == FN_MULT) && (rs_value[31] ^ rt_value[31]);
      qneg_r  <= (fn == FN_DIV) && (rs_value[31] ^ rt_value[31]);
      rneg_r  <= (fn == FN_DIV) && rs_value[31];
      divz_r  <= (rt_value == 32'd0);
      a_r     <= rs_value;
      ma_r    <= (fn == FN_MULT && rs_value[31]) ? 32'd0 - rs_value : rs_value;
      mb_r    <= (fn == FN_MULT && rt_value[31]) ? 32'd0 - rt_value : rt_value;
      dvd_r   <= (fn == FN_DIV && rs_value[31]) ? 32'd0 - rs_value : rs_value;
      dvsr_r  <= (fn == FN_DIV && rt_value[31]) ? 32'd0 - rt_value : rt_value;
      rem_r   <= '0;
      quo_r   <= '0;
      cnt_r   <= '0;
      res_r   <= {7'd0, unk, sys, tgt, br, val, dst, wr};
    end
    if (cmd.mul_lo) acc_r <= {32'd0, pp_ll} + {16'd0, pp_lh, 16'd0} + {16'd0, pp_hl, 16'd0};
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 6'd1;
      dvd_r <= {dvd_r[30:0], 1'b0};
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign result = res_r;

  // jtgt is an equivalent form kept only as a cross-check.
`ifndef SYNTH
  a_jtgt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (jtgt[31:28] == pc4[31:28]))
    else $error("jump region mismatch");
  a_nowr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (res_r[0] || (res_r[5:1] == 5'd0 && res_r[37:6] == 32'd0)))
    else $error("write fields not cleared");
  a_mul_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_step && (cmd.mul_lo || cmd.mul_hi)))
    else $error("multiply and divide overlap");
`endif

endmodule

/* sv/mips32_integer_execute.sv */
// ----------------------------------------------------------------------------
// mips32_integer_execute: MIPS32 integer execute stage.
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Most instructions may be accepted every cycle while the result register
// drains. MULT and MULTU run the capture and then the two passes of the
// 16x16 partial product multiplier. DIV and DIVU run the capture, the 32
// steps of the one-bit-per-cycle restoring divider and the sign fix. No
// item is accepted while either unit works.
module mips32_integer_execute (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: instruction, rs_value, rt_value, pc.
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: reg_write, dest_reg, write_value, branch_taken,
  // branch_target, is_syscall, is_unknown, zero fill.
  output logic [79:0]  out_tdata
);
  import mie_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .sts(sts), .cmd(cmd)
  );

  mie_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .instruction(in_tdata[31:0]), .rs_value(in_tdata[63:32]),
    .rt_value(in_tdata[95:64]), .pc(in_tdata[127:96]),
    .cmd(cmd), .sts(sts), .result(out_tdata)
  );

endmodule
